// ===== hdl/tlwt_pkg.sv =====
// Package for the tabu list with tenure: operation, status and register codes,
// default sizes and register reset values.
// No dependencies; used by tabu_list_with_tenure_top.
package tlwt_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_JOB_COUNT   = 256;

  // Field widths of the stream and register interfaces.
  localparam int OP_W     = 3;
  localparam int JOB_IN_W = 8;
  localparam int CAP_W    = 7;
  localparam int TEN_W    = 16;
  localparam int FGT_W    = 6;
  localparam int OCC_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 16;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_FIND     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMEMBER = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd2;

  // Register indexes.
  localparam logic [CFG_A_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_TENURE   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_FORGET   = 2'd2;

  // Register reset values.
  localparam logic [CAP_W-1:0] CAP_RESET    = 7'd64;
  localparam logic [TEN_W-1:0] TENURE_RESET = 16'd7;
  localparam logic [FGT_W-1:0] FORGET_RESET = 6'd0;

endpackage

// ===== hdl/tabu_list_with_tenure_top.sv =====
// Tabu list with tenure: ring of job/tenure entries in one memory, one flag per job,
// and a small sequencer that walks the ring one entry per cycle.
// Depends on tlwt_pkg.
//
//  channel  | direction | transfer when          | contents
//  s_*      | in        | s_tvalid & s_tready    | tdata: op[2:0], job[10:3]
//  m_*      | out       | m_tvalid & m_tready    | tdata: found[0], occupancy[7:1], status[9:8]
//  cfg_*    | in        | cfg_we                 | cfg_addr register index, cfg_wdata value
//
// Find, clear and unused codes go straight to the result, remember appends, and delete-oldest
// drops the oldest entry. A remember on a full list first walks the F = forget_last + 1 oldest
// entries, or gives illegal status when forget_last is not below the count. A tick walks
// the expired leading entries, then the remaining ones, through the single ring read port.
// s_tready is high only while the sequencer is idle; a result waiting on m_tready does not
// block the next transfer, but the following result waits until it is taken.
// rst is synchronous, clears flags, pointers and count, and loads the registers' reset values.
module tabu_list_with_tenure_top #(
  parameter int MAX_ENTRIES = tlwt_pkg::DEF_MAX_ENTRIES,
  parameter int JOB_COUNT   = tlwt_pkg::DEF_JOB_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tlwt_pkg::S_DATA_W-1:0]  s_tdata,   // op[2:0], job[10:3], zeros above
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tlwt_pkg::M_DATA_W-1:0]  m_tdata,   // found[0], occupancy[7:1], status[9:8]
  input  logic                           cfg_we,
  input  logic [tlwt_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [tlwt_pkg::CFG_D_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int JOB_W = $clog2(JOB_COUNT);
  localparam int CMP_W = (CNT_W > tlwt_pkg::CAP_W) ? CNT_W : tlwt_pkg::CAP_W;
  localparam int JOB_VALS = 1 << tlwt_pkg::JOB_IN_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ENTRIES);
  localparam logic [SUM_W-1:0] MAX_S = SUM_W'(MAX_ENTRIES);

  typedef struct packed {
    logic [JOB_W-1:0]          job;
    logic [tlwt_pkg::TEN_W-1:0] ten;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DROP, S_APPEND, S_EXPIRE, S_DECR, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [tlwt_pkg::CAP_W-1:0] capacity_in_use;
  logic [tlwt_pkg::TEN_W-1:0] tenure;
  logic [tlwt_pkg::FGT_W-1:0] forget_last;

  // List state.
  logic [PTR_W-1:0]     head_index;
  logic [CNT_W-1:0]     entry_count;
  logic [JOB_COUNT-1:0] member_flags;

  // Sequencer state.
  logic [JOB_W-1:0]           job_q;
  logic [CNT_W-1:0]           rd_off;
  logic [CNT_W-1:0]           proc;
  logic [CNT_W-1:0]           walk_n;
  logic                       pipe_vld;
  logic                       then_append;
  logic                       res_found;
  logic [tlwt_pkg::STAT_W-1:0] res_status;
  logic [PTR_W-1:0]           rd_slot_q;

  // Ring memory port.
  entry_t           ring_mem [MAX_ENTRIES];
  entry_t           rd_data;
  logic [PTR_W-1:0] rd_addr;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  // Input decode and derived values.
  logic [tlwt_pkg::OP_W-1:0]     op_in;
  logic [tlwt_pkg::JOB_IN_W-1:0] job_in;
  logic [JOB_W-1:0]              job_tbl [JOB_VALS];
  logic [JOB_W-1:0]              job_w;
  logic [CMP_W-1:0]              cap_ext;
  logic [CMP_W-1:0]              cap_eff;
  logic [CMP_W-1:0]              count_ext;
  logic [CMP_W-1:0]              forget_ext;
  logic                          list_full;
  logic                          in_xfer;
  logic                          out_free;
  logic                          decr_write;
  logic [tlwt_pkg::TEN_W-1:0]    ten_dec;

  // Ring slot of an offset from the head; the sum stays below twice the depth.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= MAX_S) begin
      sum = sum - MAX_S;
    end
    return sum[PTR_W-1:0];
  endfunction

  // Identifier wrap as a constant table over all input codes.
  for (genvar g = 0; g < JOB_VALS; g++) begin : g_job_tbl
    assign job_tbl[g] = JOB_W'(g % JOB_COUNT);
  end

  assign op_in  = s_tdata[tlwt_pkg::OP_W-1:0];
  assign job_in = s_tdata[tlwt_pkg::OP_W +: tlwt_pkg::JOB_IN_W];
  assign job_w  = job_tbl[job_in];

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cap_ext    = CMP_W'(capacity_in_use);
    count_ext  = CMP_W'(entry_count);
    forget_ext = CMP_W'(forget_last);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > MAX_C) begin
      cap_eff = MAX_C;
    end else begin
      cap_eff = cap_ext;
    end
    list_full = (count_ext >= cap_eff);
  end

  always_comb begin
    rd_addr    = slot_of(head_index, rd_off);
    decr_write = (state == S_DECR) && (proc != entry_count) && pipe_vld;
    ten_dec    = (rd_data.ten != '0) ? rd_data.ten - 1'b1 : rd_data.ten;
    mem_we     = (state == S_APPEND) || decr_write;
    if (state == S_APPEND) begin
      mem_waddr     = slot_of(head_index, entry_count);
      mem_wdata.job = job_q;
      mem_wdata.ten = tenure;
    end else begin
      mem_waddr     = rd_slot_q;
      mem_wdata.job = rd_data.job;
      mem_wdata.ten = ten_dec;
    end
  end

  // Ring memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      capacity_in_use <= tlwt_pkg::CAP_RESET;
      tenure          <= tlwt_pkg::TENURE_RESET;
      forget_last     <= tlwt_pkg::FORGET_RESET;
      head_index      <= '0;
      entry_count     <= '0;
      member_flags    <= '0;
      rd_off          <= '0;
      proc            <= '0;
      walk_n          <= '0;
      pipe_vld        <= 1'b0;
      then_append     <= 1'b0;
      res_found       <= 1'b0;
      res_status      <= tlwt_pkg::ST_OK;
      m_tvalid        <= 1'b0;
    end else begin
      rd_slot_q <= rd_addr;

      if (cfg_we) begin
        unique case (cfg_addr)
          tlwt_pkg::CFG_CAPACITY: capacity_in_use <= cfg_wdata[tlwt_pkg::CAP_W-1:0];
          tlwt_pkg::CFG_TENURE:   tenure          <= cfg_wdata[tlwt_pkg::TEN_W-1:0];
          tlwt_pkg::CFG_FORGET:   forget_last     <= cfg_wdata[tlwt_pkg::FGT_W-1:0];
          default: ;
        endcase
      end

      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            job_q     <= job_w;
            rd_off    <= '0;
            proc      <= '0;
            pipe_vld  <= 1'b0;
            res_found <= (op_in == tlwt_pkg::OP_FIND) && (entry_count != '0) &&
                         member_flags[job_w];
            unique case (op_in)
              tlwt_pkg::OP_FIND: begin
                res_status <= tlwt_pkg::ST_OK;
                state      <= S_DONE;
              end
              tlwt_pkg::OP_REMEMBER: begin
                if (!list_full) begin
                  res_status <= tlwt_pkg::ST_OK;
                  state      <= S_APPEND;
                end else if (forget_ext >= count_ext) begin
                  res_status <= tlwt_pkg::ST_ILLEGAL;
                  state      <= S_DONE;
                end else begin
                  res_status  <= tlwt_pkg::ST_OK;
                  walk_n      <= CNT_W'(forget_ext + CMP_W'(1));
                  then_append <= 1'b1;
                  state       <= S_DROP;
                end
              end
              tlwt_pkg::OP_TICK: begin
                res_status <= tlwt_pkg::ST_OK;
                state      <= S_EXPIRE;
              end
              tlwt_pkg::OP_DELETE: begin
                if (entry_count == '0) begin
                  res_status <= tlwt_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  res_status  <= tlwt_pkg::ST_OK;
                  walk_n      <= CNT_W'(1);
                  then_append <= 1'b0;
                  state       <= S_DROP;
                end
              end
              tlwt_pkg::OP_CLEAR: begin
                member_flags <= '0;
                head_index   <= '0;
                entry_count  <= '0;
                res_status   <= tlwt_pkg::ST_OK;
                state        <= S_DONE;
              end
              default: begin
                res_status <= tlwt_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // Reads run one entry ahead of the flag clearing.
        S_DROP: begin
          rd_off   <= rd_off + 1'b1;
          pipe_vld <= 1'b1;
          if (pipe_vld) begin
            member_flags[rd_data.job] <= 1'b0;
            proc <= proc + 1'b1;
            if (proc + 1'b1 == walk_n) begin
              head_index  <= slot_of(head_index, walk_n);
              entry_count <= entry_count - walk_n;
              state       <= then_append ? S_APPEND : S_DONE;
            end
          end
        end

        S_APPEND: begin
          entry_count         <= entry_count + 1'b1;
          member_flags[job_q] <= 1'b1;
          state               <= S_DONE;
        end

        // Leading entries with tenure of one or less leave the list.
        S_EXPIRE: begin
          if (proc == entry_count || (pipe_vld && rd_data.ten > 16'd1)) begin
            head_index  <= slot_of(head_index, proc);
            entry_count <= entry_count - proc;
            rd_off      <= '0;
            proc        <= '0;
            pipe_vld    <= 1'b0;
            state       <= S_DECR;
          end else begin
            rd_off   <= rd_off + 1'b1;
            pipe_vld <= 1'b1;
            if (pipe_vld) begin
              member_flags[rd_data.job] <= 1'b0;
              proc <= proc + 1'b1;
            end
          end
        end

        // Each remaining entry is read, then written back one lower, saturating at zero.
        S_DECR: begin
          rd_off   <= rd_off + 1'b1;
          pipe_vld <= 1'b1;
          if (proc == entry_count) begin
            state <= S_DONE;
          end else if (pipe_vld) begin
            proc <= proc + 1'b1;
          end
        end

        S_DONE: begin
          if (out_free) begin
            m_tdata <= {6'b0, res_status, tlwt_pkg::OCC_W'(entry_count), res_found};
            state   <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A clear leaves an empty list with the head at slot zero.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op_in == tlwt_pkg::OP_CLEAR |=> entry_count == '0 && head_index == '0
  ) else $error("clear did not empty the list");

  // A find never changes the list.
  a_find_stable: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op_in == tlwt_pkg::OP_FIND |=> $stable(entry_count) && $stable(head_index)
  ) else $error("find changed the list");

  // An append adds exactly one entry.
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |=> entry_count == $past(entry_count) + 1'b1
  ) else $error("append did not add one entry");

  // The walk position never passes the end of the list.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXPIRE || state == S_DECR) |-> proc <= entry_count
  ) else $error("walk ran past the list");

  // The list never holds more entries than the ring.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(entry_count) <= MAX_C
  ) else $error("entry count above ring depth");

endmodule
